@@ design/spl1_pkg.sv @@
// Shared types, constants and the reciprocal table for the smoothed-L1 penalty block.
// No dependencies; every other design file imports this package.
`default_nettype none

package spl1_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int IQ          = 30;
    localparam int ACC_WIDTH   = 48;
    localparam int QUEUE_DEPTH = 2;
    localparam int DIV_STEPS   = 64;
    localparam int EXP_TERMS   = 20;
    localparam int LOG_TERMS   = 13;

    localparam logic [30:0] ONE_IQ   = 31'h4000_0000;
    localparam logic [30:0] EPS_RST  = 31'(100 << FRAC_BITS);
    localparam logic [63:0] DEN      = 64'd4294967296;

    // ceil(2^32 / d); entries for 0 and 1 are unused (divide by one is a bypass)
    localparam logic [31:0] RECIP [26] = '{
        32'd0, 32'd0,
        32'((DEN + 64'd1)  / 64'd2),  32'((DEN + 64'd2)  / 64'd3),
        32'((DEN + 64'd3)  / 64'd4),  32'((DEN + 64'd4)  / 64'd5),
        32'((DEN + 64'd5)  / 64'd6),  32'((DEN + 64'd6)  / 64'd7),
        32'((DEN + 64'd7)  / 64'd8),  32'((DEN + 64'd8)  / 64'd9),
        32'((DEN + 64'd9)  / 64'd10), 32'((DEN + 64'd10) / 64'd11),
        32'((DEN + 64'd11) / 64'd12), 32'((DEN + 64'd12) / 64'd13),
        32'((DEN + 64'd13) / 64'd14), 32'((DEN + 64'd14) / 64'd15),
        32'((DEN + 64'd15) / 64'd16), 32'((DEN + 64'd16) / 64'd17),
        32'((DEN + 64'd17) / 64'd18), 32'((DEN + 64'd18) / 64'd19),
        32'((DEN + 64'd19) / 64'd20), 32'((DEN + 64'd20) / 64'd21),
        32'((DEN + 64'd21) / 64'd22), 32'((DEN + 64'd22) / 64'd23),
        32'((DEN + 64'd23) / 64'd24), 32'((DEN + 64'd24) / 64'd25)
    };

    typedef enum logic [1:0] {
        REG_SMOOTHING     = 2'd0,
        REG_WEIGHT_SINGLE = 2'd1,
        REG_WEIGHT_PAIR   = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [31:0]        xabs;
        logic               xneg;
        logic signed [31:0] grad;
        logic [30:0]        weight;
        logic               last;
    } t_job;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
    } t_div_rsp;

    typedef enum logic [4:0] {
        S_IDLE, S_TMUL, S_TSPLIT,
        S_SER_MUL, S_SER_REC, S_SER_FIX,
        S_UPOW_MUL, S_UPOW_ACC,
        S_TH_START, S_TH_WAIT, S_Z_START, S_Z_WAIT,
        S_Z2_MUL, S_Z2_GET,
        S_LOG_REC, S_LOG_FIX, S_LOG_MUL, S_LOG_NEXT,
        S_DELTA_MUL, S_DELTA_GET, S_WX_GET, S_WL_GET,
        S_PEN_WAIT, S_DONE
    } t_back_state;

endpackage

`default_nettype wire

@@ design/spl1_front.sv @@
// Front end: accepts stream items, takes |x| and sign, selects the weight.
// Depends on spl1_pkg.
`default_nettype none

module spl1_front (
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [31:0]       i_param_value,
    input  wire logic [31:0]       i_grad_in,
    input  wire logic              i_is_pair,
    input  wire logic              i_last,
    input  wire logic [30:0]       i_weight_single,
    input  wire logic [30:0]       i_weight_pair,
    input  wire logic              i_full,
    output logic                   o_push,
    output spl1_pkg::t_job         o_job
);
    import spl1_pkg::*;

    always_comb begin
        o_ready       = !i_full;
        o_push        = i_valid && !i_full;
        o_job.xneg    = i_param_value[31];
        o_job.xabs    = i_param_value[31] ? (32'd0 - i_param_value) : i_param_value;
        o_job.grad    = i_grad_in;
        o_job.weight  = i_is_pair ? i_weight_pair : i_weight_single;
        o_job.last    = i_last;
    end

endmodule

`default_nettype wire

@@ design/spl1_queue.sv @@
// Small FIFO of classified items between the front and back ends.
// Depends on spl1_pkg.
`default_nettype none

module spl1_queue #(
    parameter int DEPTH = spl1_pkg::QUEUE_DEPTH
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire spl1_pkg::t_job             i_job,
    input  wire logic                       i_pop,
    output spl1_pkg::t_job                  o_job,
    output logic                            o_full,
    output logic                            o_nonempty,
    output logic [$clog2(DEPTH+1)-1:0]      o_count
);
    import spl1_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;

    always_comb begin
        o_job      = r_mem[r_rd];
        o_full     = (r_count == CW'(DEPTH));
        o_nonempty = (r_count != '0);
        o_count    = r_count;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ design/spl1_div.sv @@
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 32-bit divisor.
// Depends on spl1_pkg.
`default_nettype none

module spl1_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire spl1_pkg::t_div_req i_req,
    output spl1_pkg::t_div_rsp      o_rsp
);
    import spl1_pkg::*;

    localparam int SW = $clog2(DIV_STEPS);

    logic          r_busy;
    logic          r_done;
    logic [SW-1:0] r_cnt;
    logic [31:0]   r_rem;
    logic [63:0]   r_quo;
    logic [31:0]   r_div;
    logic [32:0]   w_sh;
    logic          w_ge;

    always_comb begin
        w_sh           = {r_rem, r_quo[63]};
        w_ge           = (w_sh >= {1'b0, r_div});
        o_rsp.done     = r_done;
        o_rsp.quotient = r_quo;
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? 32'(w_sh - {1'b0, r_div}) : w_sh[31:0];
            r_quo <= {r_quo[62:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == SW'(DIV_STEPS - 1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == SW'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ design/spl1_back.sv @@
// Back end: sequencer over one shared multiplier and the divider; computes
// e^-|t|, tanh, log term, gradient, penalty, running sum and output register.
// Depends on spl1_pkg and spl1_div.
`default_nettype none

module spl1_back #(
    parameter int ACC_W = spl1_pkg::ACC_WIDTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic [30:0]    i_smoothing,
    input  wire logic           i_job_valid,
    input  wire spl1_pkg::t_job i_job,
    output logic                o_pop,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic [31:0]         o_grad,
    output logic [ACC_W-1:0]    o_sum,
    output logic                o_last
);
    import spl1_pkg::*;

    t_back_state r_state, n_state;
    t_job        r_job;
    t_div_req    w_dreq;
    t_div_rsp    w_drsp;

    logic [63:0] r_prod;
    logic [31:0] w_ma, w_mb;
    logic [30:0] w_eps;

    logic [4:0]  r_n5;
    logic [29:0] r_f30;
    logic        r_phase_u;
    logic [30:0] r_f, r_term, r_v, r_e1, r_u, r_th, r_z, r_z2, r_p, r_sum, r_delta;
    logic [31:0] r_pos, r_neg;
    logic [4:0]  r_k, r_d, r_cnt;
    logic [46:0] r_wx;
    logic [63:0] r_pen;
    logic [ACC_W-1:0] r_acc;
    logic        r_out_valid;
    logic [31:0] r_out_grad;
    logic [ACC_W-1:0] r_out_sum;
    logic        r_out_last;

    logic [30:0] w_q0, w_qfix, w_ser_res;
    logic [35:0] w_qk;
    logic [31:0] w_pos_n, w_neg_n;
    logic        w_out_free;
    logic signed [33:0] w_gsum;
    logic [31:0] w_gsat;
    logic [ACC_W-1:0] w_room, w_acc_n;

    spl1_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_rsp   (w_drsp)
    );

    // shared arithmetic helpers
    always_comb begin
        w_eps      = (i_smoothing == '0) ? 31'd1 : i_smoothing;
        w_q0       = r_prod[62:32];
        w_qk       = 36'(w_q0) * 36'(r_d);
        // reciprocal estimate is exact or one too high
        if (r_d == 5'd1) begin
            w_qfix = r_v;
        end else if (w_qk > 36'(r_v)) begin
            w_qfix = w_q0 - 1'b1;
        end else begin
            w_qfix = w_q0;
        end
        w_pos_n    = r_k[0] ? r_pos : r_pos + 32'(w_qfix);
        w_neg_n    = r_k[0] ? r_neg + 32'(w_qfix) : r_neg;
        w_ser_res  = (w_pos_n > w_neg_n) ? 31'(w_pos_n - w_neg_n) : '0;
        w_out_free = !r_out_valid || i_ready;
        w_gsum     = r_job.xneg ? (34'(r_job.grad) - 34'(signed'({3'b000, r_delta})))
                                : (34'(r_job.grad) + 34'(signed'({3'b000, r_delta})));
        if (w_gsum > 34'sd2147483647) begin
            w_gsat = 32'h7FFF_FFFF;
        end else if (w_gsum < -34'sd2147483648) begin
            w_gsat = 32'h8000_0000;
        end else begin
            w_gsat = w_gsum[31:0];
        end
        w_room     = {ACC_W{1'b1}} - r_acc;
        w_acc_n    = (r_pen > 64'(w_room)) ? {ACC_W{1'b1}} : r_acc + ACC_W'(r_pen);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (i_job_valid) n_state = S_TMUL;
            S_TMUL:      n_state = S_TSPLIT;
            S_TSPLIT:    n_state = (r_prod[62:37] == '0) ? S_SER_MUL : S_TH_START;
            S_SER_MUL:   n_state = S_SER_REC;
            S_SER_REC:   n_state = S_SER_FIX;
            S_SER_FIX: begin
                if (r_k != 5'(EXP_TERMS)) n_state = S_SER_MUL;
                else if (!r_phase_u)      n_state = S_SER_MUL;
                else if (r_n5 == '0)      n_state = S_TH_START;
                else                      n_state = S_UPOW_MUL;
            end
            S_UPOW_MUL:  n_state = S_UPOW_ACC;
            S_UPOW_ACC:  n_state = (r_cnt + 1'b1 == r_n5) ? S_TH_START : S_UPOW_MUL;
            S_TH_START:  n_state = S_TH_WAIT;
            S_TH_WAIT:   if (w_drsp.done) n_state = S_Z_START;
            S_Z_START:   n_state = S_Z_WAIT;
            S_Z_WAIT:    if (w_drsp.done) n_state = S_Z2_MUL;
            S_Z2_MUL:    n_state = S_Z2_GET;
            S_Z2_GET:    n_state = S_LOG_REC;
            S_LOG_REC:   n_state = S_LOG_FIX;
            S_LOG_FIX:   n_state = (r_k == 5'(LOG_TERMS - 1)) ? S_DELTA_MUL : S_LOG_MUL;
            S_LOG_MUL:   n_state = S_LOG_NEXT;
            S_LOG_NEXT:  n_state = S_LOG_REC;
            S_DELTA_MUL: n_state = S_DELTA_GET;
            S_DELTA_GET: n_state = S_WX_GET;
            S_WX_GET:    n_state = S_WL_GET;
            S_WL_GET:    n_state = S_PEN_WAIT;
            S_PEN_WAIT:  if (w_drsp.done) n_state = S_DONE;
            S_DONE:      if (w_out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // multiplier operands, divider requests, queue pop
    always_comb begin
        w_ma   = '0;
        w_mb   = '0;
        w_dreq = '0;
        o_pop  = 1'b0;
        unique case (r_state)
            S_IDLE:      o_pop = i_job_valid;
            S_TMUL:      begin w_ma = 32'(w_eps);        w_mb = r_job.xabs; end
            S_SER_MUL:   begin w_ma = 32'(r_term);       w_mb = 32'(r_f); end
            S_SER_REC:   begin w_ma = 32'(r_prod[60:30]); w_mb = RECIP[r_k]; end
            S_UPOW_MUL:  begin w_ma = 32'(r_u);          w_mb = 32'(r_e1); end
            S_Z2_MUL:    begin w_ma = 32'(r_z);          w_mb = 32'(r_z); end
            S_LOG_REC:   begin w_ma = 32'(r_p);          w_mb = RECIP[{r_k[3:0], 1'b1}]; end
            S_LOG_MUL:   begin w_ma = 32'(r_p);          w_mb = 32'(r_z2); end
            S_DELTA_MUL: begin w_ma = 32'(r_job.weight); w_mb = 32'(r_th); end
            S_DELTA_GET: begin w_ma = 32'(r_job.weight); w_mb = r_job.xabs; end
            S_WX_GET:    begin w_ma = 32'(r_job.weight); w_mb = {r_sum, 1'b0}; end
            S_TH_START: begin
                w_dreq.start    = 1'b1;
                w_dreq.dividend = 64'(ONE_IQ - r_u) << IQ;
                w_dreq.divisor  = 32'(ONE_IQ) + 32'(r_u);
            end
            S_Z_START: begin
                w_dreq.start    = 1'b1;
                w_dreq.dividend = 64'(r_u) << IQ;
                w_dreq.divisor  = 32'h8000_0000 + 32'(r_u);
            end
            S_WL_GET: begin
                w_dreq.start    = 1'b1;
                w_dreq.dividend = r_prod << 1;
                w_dreq.divisor  = 32'(w_eps);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(w_ma) * 64'(w_mb);
        case (r_state)
            S_IDLE: if (i_job_valid) r_job <= i_job;
            S_TSPLIT: begin
                r_n5      <= r_prod[36:32];
                r_f30     <= r_prod[31:2];
                r_phase_u <= 1'b0;
                r_f       <= ONE_IQ;
                r_term    <= ONE_IQ;
                r_pos     <= 32'(ONE_IQ);
                r_neg     <= '0;
                r_k       <= 5'd1;
                r_cnt     <= '0;
                r_u       <= '0;
            end
            S_SER_REC: begin
                r_v <= r_prod[60:30];
                r_d <= r_k;
            end
            S_SER_FIX: begin
                r_term <= w_qfix;
                r_pos  <= w_pos_n;
                r_neg  <= w_neg_n;
                r_k    <= r_k + 1'b1;
                if (r_k == 5'(EXP_TERMS)) begin
                    if (!r_phase_u) begin
                        // e^-1 done, restart the series on the fraction
                        r_e1      <= w_ser_res;
                        r_phase_u <= 1'b1;
                        r_f       <= {1'b0, r_f30};
                        r_term    <= ONE_IQ;
                        r_pos     <= 32'(ONE_IQ);
                        r_neg     <= '0;
                        r_k       <= 5'd1;
                    end else begin
                        r_u <= w_ser_res;
                    end
                end
            end
            S_UPOW_ACC: begin
                r_u   <= r_prod[60:30];
                r_cnt <= r_cnt + 1'b1;
            end
            S_TH_WAIT: if (w_drsp.done) r_th <= w_drsp.quotient[30:0];
            S_Z_WAIT:  if (w_drsp.done) r_z  <= w_drsp.quotient[30:0];
            S_Z2_GET: begin
                r_z2  <= r_prod[60:30];
                r_p   <= r_z;
                r_sum <= '0;
                r_k   <= '0;
            end
            S_LOG_REC: begin
                r_v <= r_p;
                r_d <= {r_k[3:0], 1'b1};
            end
            S_LOG_FIX:   r_sum   <= r_sum + w_qfix;
            S_LOG_NEXT: begin
                r_p <= r_prod[60:30];
                r_k <= r_k + 1'b1;
            end
            S_DELTA_GET: r_delta <= r_prod[60:30];
            S_WX_GET:    r_wx    <= r_prod[62:16];
            S_PEN_WAIT: if (w_drsp.done) begin
                r_pen <= 64'(r_wx) + (w_drsp.quotient >> (IQ - FRAC_BITS));
            end
            S_DONE: if (w_out_free) begin
                r_out_grad <= w_gsat;
                r_out_sum  <= w_acc_n;
                r_out_last <= r_job.last;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_acc       <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
                r_acc       <= r_job.last ? '0 : w_acc_n;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_valid = r_out_valid;
        o_grad  = r_out_grad;
        o_sum   = r_out_sum;
        o_last  = r_out_last;
    end

endmodule

`default_nettype wire

@@ design/softplus_l1_penalty_gradient.sv @@
// Smoothed-L1 penalty and gradient update, one stream item in, one result out.
// The back-end sequence grows with n = integer part of eps*|x| (< 32) and is
// shortest when eps*|x| >= 32. One item is worked at a time; the rate is set
// by the shared multiplier sequence and three 64-step divider runs.
// A two-entry queue lets the input take items while the back end is busy.
// Reset (i_rst_n low, synchronous): clears the queue, sequencer, output valid
// and running sum; smoothing returns to 100.0, both weights to zero.
`default_nettype none

module softplus_l1_penalty_gradient #(
    parameter int ACC_WIDTH = spl1_pkg::ACC_WIDTH,
    parameter int OUT_W     = ((32 + ACC_WIDTH + 7) / 8) * 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // configuration write channel
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [1:0]       i_cfg_index,
    input  wire logic [30:0]      i_cfg_data,
    // input items
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [63:0]      s_axis_tdata,   // [31:0] param_value, [63:32] grad_in
    input  wire logic             s_axis_tuser,   // is_pair
    input  wire logic             s_axis_tlast,   // last
    // result items
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata,   // [31:0] grad_out, then penalty_sum
    output logic                  m_axis_tlast    // sum_valid
);
    import spl1_pkg::*;

    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    logic [30:0]    r_smoothing;
    logic [30:0]    r_weight_single;
    logic [30:0]    r_weight_pair;

    t_job           w_front_job;
    t_job           w_head_job;
    logic           w_push;
    logic           w_pop;
    logic           w_full;
    logic           w_nonempty;
    logic [QCW-1:0] w_count;
    logic [31:0]    w_grad;
    logic [ACC_WIDTH-1:0] w_sum;

    // Configuration registers; writes are always taken, unknown index dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smoothing     <= EPS_RST;
            r_weight_single <= '0;
            r_weight_pair   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SMOOTHING:     r_smoothing     <= i_cfg_data;
                REG_WEIGHT_SINGLE: r_weight_single <= i_cfg_data;
                REG_WEIGHT_PAIR:   r_weight_pair   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Front end: classify the item and push it into the queue.
    spl1_front u_front (
        .i_valid         (s_axis_tvalid),
        .o_ready         (s_axis_tready),
        .i_param_value   (s_axis_tdata[31:0]),
        .i_grad_in       (s_axis_tdata[63:32]),
        .i_is_pair       (s_axis_tuser),
        .i_last          (s_axis_tlast),
        .i_weight_single (r_weight_single),
        .i_weight_pair   (r_weight_pair),
        .i_full          (w_full),
        .o_push          (w_push),
        .o_job           (w_front_job)
    );

    // Queue decouples the front end from the long back-end sequence.
    spl1_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_job      (w_front_job),
        .i_pop      (w_pop),
        .o_job      (w_head_job),
        .o_full     (w_full),
        .o_nonempty (w_nonempty),
        .o_count    (w_count)
    );

    // Back end: exp/log/tanh evaluation, gradient and penalty, output register.
    spl1_back #(
        .ACC_W (ACC_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_smoothing (r_smoothing),
        .i_job_valid (w_nonempty),
        .i_job       (w_head_job),
        .o_pop       (w_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_grad      (w_grad),
        .o_sum       (w_sum),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_W'({w_sum, w_grad});

    // Queue bookkeeping checks across the front and back ends.
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (w_count != QCW'(QUEUE_DEPTH)))
        else $error("push into a full queue");

    a_pop_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> (w_count != '0))
        else $error("pop from an empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (w_count == $past(w_count) + 1'b1))
        else $error("queue count did not advance on push");

endmodule

`default_nettype wire
